[rtl/nqsc_pkg.sv]
// Shared types and constants for the N-queens solution counter.
package nqsc_pkg;

  localparam int ROW_W      = 4;   // bits per column in a placement word
  localparam int PLACE_W    = 52;
  localparam int PLACE_COLS = PLACE_W / ROW_W;
  localparam int TALLY_W    = 17;
  localparam int LIST_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [TALLY_W-1:0]    TALLY_MAX   = '1;
  localparam logic [CFG_DATA_W-1:0] BOARD_RESET = 4'd8;
  localparam logic [LIST_W-1:0]     LIST_RESET  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LIMIT = 1'b1;

  localparam logic KIND_SOLUTION = 1'b0;
  localparam logic KIND_COUNT    = 1'b1;

  typedef struct packed {
    logic init;  // clear search state for a fresh run
    logic step;  // advance the search by one node
  } cmd_t;

  typedef struct packed {
    logic done;  // a step now would exhaust the search at the root
  } status_t;

endpackage

[rtl/nqsc_ctrl.sv]
// Run controller for the N-queens solution counter.
module nqsc_ctrl
  import nqsc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    start_req_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.init = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && start_req_i) begin
          cmd_o.init = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (status_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[rtl/nqsc_datapath.sv]
// Search datapath: board masks, queen stack, tallies and result register.
module nqsc_datapath
  import nqsc_pkg::*;
#(
  parameter int MAX_BOARD = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmd_t                              cmd_i,
  input  logic [$clog2(MAX_BOARD+1)-1:0]    board_n_i,
  input  logic [LIST_W-1:0]                 list_limit_i,
  output status_t                           status_o,
  output logic                              result_valid_o,
  output logic                              kind_o,
  output logic [PLACE_W-1:0]                placement_o,
  output logic [TALLY_W-1:0]                total_solutions_o,
  output logic                              last_o
);

  localparam int DW     = $clog2(MAX_BOARD + 1);
  localparam int IW     = $clog2(MAX_BOARD);
  localparam int DIAG_W = 2 * MAX_BOARD - 1;
  localparam int DIW    = $clog2(DIAG_W);
  localparam int NPACK  = (MAX_BOARD < PLACE_COLS) ? MAX_BOARD : PLACE_COLS;

  logic [ROW_W-1:0]     queen_q [MAX_BOARD];
  logic [MAX_BOARD-1:0] rows_q, rows_d;
  logic [DIAG_W-1:0]    up_q, up_d, dn_q, dn_d;
  logic [DW-1:0]        depth_q, depth_d, try_q, try_d;
  logic                 sol_q, sol_d;
  logic [TALLY_W-1:0]   tally_q, tally_d;
  logic [LIST_W-1:0]    listed_q, listed_d;

  logic                 res_valid_q, res_valid_d;
  logic                 kind_q, kind_d, last_q, last_d;
  logic [PLACE_W-1:0]   place_q, place_d;
  logic [TALLY_W-1:0]   total_q, total_d;

  logic [MAX_BOARD-1:0] up_win, dn_win, row_ok, free_rows;
  logic [DIW-1:0]       dn_amt, place_up, place_dn, back_up, back_dn;
  logic [IW-1:0]        pick;
  logic                 found, at_leaf, queen_we;
  logic [DW-1:0]        back_d;
  logic [ROW_W-1:0]     back_row;
  logic [PLACE_W-1:0]   packed_board;

  // Diagonal windows aligned to the current column.
  assign dn_amt = DIW'(MAX_BOARD - 1) - DIW'(depth_q);
  assign up_win = MAX_BOARD'(up_q >> depth_q);
  assign dn_win = MAX_BOARD'(dn_q >> dn_amt);

  always_comb begin
    for (int j = 0; j < MAX_BOARD; j++) begin
      row_ok[j] = (DW'(j) >= try_q) && (DW'(j) < board_n_i);
    end
    free_rows = ~(rows_q | up_win | dn_win) & row_ok;
    found = 1'b0;
    pick  = '0;
    for (int j = MAX_BOARD - 1; j >= 0; j--) begin
      if (free_rows[j]) begin
        found = 1'b1;
        pick  = IW'(j);
      end
    end
  end

  assign at_leaf  = (depth_q == board_n_i);
  assign back_d   = depth_q - DW'(1);
  assign back_row = queen_q[back_d[IW-1:0]];
  assign place_up = DIW'(pick) + DIW'(depth_q);
  assign place_dn = DIW'(pick) + dn_amt;
  assign back_up  = DIW'(back_row) + DIW'(back_d);
  assign back_dn  = DIW'(back_row) + DIW'(MAX_BOARD - 1) - DIW'(back_d);

  // Columns past the board size may hold stale rows; mask them out.
  always_comb begin
    packed_board = '0;
    for (int c = 0; c < NPACK; c++) begin
      if (DW'(c) < board_n_i) begin
        packed_board[c*ROW_W +: ROW_W] = queen_q[c];
      end
    end
  end

  assign status_o.done = !(at_leaf && !sol_q) && !(!at_leaf && found) && (depth_q == '0);

  always_comb begin
    rows_d      = rows_q;
    up_d        = up_q;
    dn_d        = dn_q;
    depth_d     = depth_q;
    try_d       = try_q;
    sol_d       = sol_q;
    tally_d     = tally_q;
    listed_d    = listed_q;
    queen_we    = 1'b0;
    res_valid_d = 1'b0;
    kind_d      = KIND_SOLUTION;
    last_d      = 1'b0;
    place_d     = '0;
    total_d     = '0;
    if (cmd_i.init) begin
      rows_d   = '0;
      up_d     = '0;
      dn_d     = '0;
      depth_d  = '0;
      try_d    = '0;
      sol_d    = 1'b0;
      tally_d  = '0;
      listed_d = '0;
    end else if (cmd_i.step) begin
      if (at_leaf && !sol_q) begin
        // Full board: count it, list it if room; backtrack on the next step.
        sol_d = 1'b1;
        if (tally_q != TALLY_MAX) begin
          tally_d = tally_q + TALLY_W'(1);
        end
        if (listed_q < list_limit_i) begin
          listed_d    = listed_q + LIST_W'(1);
          res_valid_d = 1'b1;
          place_d     = packed_board;
        end
      end else if (!at_leaf && found) begin
        queen_we       = 1'b1;
        rows_d[pick]   = 1'b1;
        up_d[place_up] = 1'b1;
        dn_d[place_dn] = 1'b1;
        depth_d        = depth_q + DW'(1);
        try_d          = '0;
      end else begin
        sol_d = 1'b0;
        if (depth_q == '0) begin
          res_valid_d = 1'b1;
          kind_d      = KIND_COUNT;
          last_d      = 1'b1;
          total_d     = tally_q;
        end else begin
          depth_d                   = back_d;
          rows_d[back_row[IW-1:0]]  = 1'b0;
          up_d[back_up]             = 1'b0;
          dn_d[back_dn]             = 1'b0;
          try_d                     = DW'(back_row) + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= '0;
      up_q        <= '0;
      dn_q        <= '0;
      depth_q     <= '0;
      try_q       <= '0;
      sol_q       <= 1'b0;
      tally_q     <= '0;
      listed_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      rows_q      <= rows_d;
      up_q        <= up_d;
      dn_q        <= dn_d;
      depth_q     <= depth_d;
      try_q       <= try_d;
      sol_q       <= sol_d;
      tally_q     <= tally_d;
      listed_q    <= listed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (queen_we) begin
      queen_q[depth_q[IW-1:0]] <= ROW_W'(pick);
    end
    kind_q  <= kind_d;
    last_q  <= last_d;
    place_q <= place_d;
    total_q <= total_d;
  end

  assign result_valid_o    = res_valid_q;
  assign kind_o            = kind_q;
  assign placement_o       = place_q;
  assign total_solutions_o = total_q;
  assign last_o            = last_q;

endmodule

[rtl/n_queens_solution_counter.sv]
// Top level of the N-queens solution counter: config registers, controller, datapath.
//
// A request with start_req_i set, taken when start_i is high and busy_o is low, runs a
// full depth-first N-queens search on a board of board_size rows (clamped to MAX_BOARD).
// busy_o stays high for the whole run; a request with start_req_i low is taken and does
// nothing. Results come out one cycle at a time on result_valid_o and cannot be held
// off: up to list_limit solutions (kind_o 0, placement_o packs the 0-based row of each
// column at 4 bits, column one lowest), then one count item (kind_o 1,
// total_solutions_o, last_o set) in the cycle busy_o falls. The datapath takes one step
// per cycle (place a queen, count a full board or back up one column).
// Configure only while idle.
module n_queens_solution_counter
  import nqsc_pkg::*;
#(
  parameter int MAX_BOARD = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  start_req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic                  kind_o,
  output logic [PLACE_W-1:0]    placement_o,
  output logic [TALLY_W-1:0]    total_solutions_o,
  output logic                  last_o
);

  localparam int DW = $clog2(MAX_BOARD + 1);

  logic [CFG_DATA_W-1:0] board_size_q;
  logic [LIST_W-1:0]     list_limit_q;
  logic [4:0]            board_ext;
  logic [DW-1:0]         board_n;
  cmd_t                  cmd;
  status_t               status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= BOARD_RESET;
      list_limit_q <= LIST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BOARD_SIZE: board_size_q <= cfg_data_i;
        CFG_LIST_LIMIT: list_limit_q <= cfg_data_i[LIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign board_ext = {1'b0, board_size_q};
  assign board_n   = (board_ext > 5'(MAX_BOARD)) ? DW'(MAX_BOARD) : DW'(board_ext);

  nqsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .start_req_i (start_req_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  nqsc_datapath #(
    .MAX_BOARD (MAX_BOARD)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .board_n_i         (board_n),
    .list_limit_i      (list_limit_q),
    .status_o          (status),
    .result_valid_o    (result_valid_o),
    .kind_o            (kind_o),
    .placement_o       (placement_o),
    .total_solutions_o (total_solutions_o),
    .last_o            (last_o)
  );

  // The count item closes the run: it is the only last item and busy has dropped.
  a_last_is_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> kind_o == KIND_COUNT)
    else $error("last set on a listed solution");

  a_count_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_COUNT |-> !busy_o && $past(busy_o))
    else $error("count item outside the end of a run");

  a_solution_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_SOLUTION |-> busy_o)
    else $error("listed solution while idle");

endmodule
